// ===== src/slcp_pkg.sv =====
package slcp_pkg;

    localparam int LINE_BYTES_DEF = 64;
    localparam int CHANNELS_DEF   = 4;
    localparam int DUTY_BITS_DEF  = 8;

    localparam int BRIGHT_W = 7;
    localparam int NUM_W    = 17;

    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX   = 7'd100;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd75;
    localparam logic [NUM_W-1:0]    NUM_SAT      = 17'h10000;

    // reply codes
    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_INFO = 2'd1;
    localparam logic [1:0] REPLY_ERR  = 2'd2;

    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [4:0] DIGIT_BAD  = 5'd16;

    // command text, right aligned in 11 bytes
    localparam logic [87:0] STR_PING   = 88'("PING");
    localparam logic [87:0] STR_INFO   = 88'("INFO");
    localparam logic [87:0] STR_OFF    = 88'("OFF");
    localparam logic [87:0] STR_RESET  = 88'("RESET");
    localparam logic [87:0] STR_BRIGHT = 88'("BRIGHTNESS");
    localparam logic [87:0] STR_MASK   = 88'("MASK ");
    localparam logic [87:0] STR_M      = 88'("M");

    // 2^30/100 rounded up, exact quotient for products below 2^23
    localparam int          RECIP_SHIFT = 30;
    localparam logic [23:0] RECIP_100   = 24'd10737419;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MATCH,
        ST_DECIDE,
        ST_MUL1,
        ST_MUL2,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        NUM_LEAD,
        NUM_SIGN,
        NUM_ZERO,
        NUM_ZX,
        NUM_DIG,
        NUM_FAIL
    } num_state_t;

    typedef struct packed {
        logic store;
        logic line_end;
        logic clr_discard;
        logic overflow;
        logic scan;
        logic match_start;
        logic match;
        logic decide;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic eol;
        logic discarding;
        logic len_zero;
        logic len_full;
        logic scan_done;
        logic nonempty;
        logic match_done;
        logic out_free;
    } dp_stat_t;

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CHAR_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            t = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            t = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            t = c - 8'h37;
        end
        else
        begin
            t = 8'(DIGIT_BAD);
        end
        digit_of = t[4:0];
    endfunction

    // character k of a right aligned string of len characters
    function automatic logic [7:0] str_char(input logic [87:0] s, input logic [3:0] len,
                                            input logic [3:0] k);
        logic [3:0] idx;
        idx = len - 4'd1 - k;
        str_char = s[{idx, 3'b000} +: 8];
    endfunction

endpackage

// ===== src/serial_line_light_command_parser_core.sv =====
// serial light command parser: bytes come in on the s_ side, one per item, and
// are collected into a line of up to LINE_BYTES-1 bytes that CR or LF closes.
// a line end walks the stored line once to find the zero cut and trimmed ends
// and, if any text is left, once over the trimmed text to match keywords and
// read numbers, then passes a decision step and the two duty multiplies; the
// single-port line buffer is read one byte a cycle on both walks. the block
// takes no byte while a line is walked. a result (reply, channel mask, duty,
// brightness) waits in an output register, and further bytes are taken
// meanwhile until one needs a new result. an overlong line gives one error
// item and its remaining bytes are dropped
module serial_line_light_command_parser_core
    import slcp_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int DUTY_BITS  = DUTY_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    // rx_byte
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    // reply, channel_mask, on_duty, brightness, zero fill
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [((2 + CHANNELS + DUTY_BITS + BRIGHT_W + 7) / 8) * 8 - 1:0] m_tdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: line collection, two walks, decision, result hand-off
    slcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // line buffer, keyword flags, number readers, duty math, output register
    slcp_dp #(
        .LINE_BYTES (LINE_BYTES),
        .CHANNELS   (CHANNELS),
        .DUTY_BITS  (DUTY_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== src/slcp_ctrl.sv =====
module slcp_ctrl
    import slcp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (stat.eol)
                    begin
                        if (stat.discarding)
                        begin
                            cmd.clr_discard = 1'b1;
                        end
                        else if (!stat.len_zero)
                        begin
                            cmd.line_end = 1'b1;
                            state_next   = ST_SCAN;
                        end
                    end
                    else if (!stat.discarding)
                    begin
                        if (stat.len_full)
                        begin
                            cmd.overflow = 1'b1;
                            state_next   = ST_MUL1;
                        end
                        else
                        begin
                            cmd.store = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.nonempty)
                    begin
                        cmd.match_start = 1'b1;
                        state_next      = ST_MATCH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MATCH:
            begin
                cmd.match = 1'b1;
                if (stat.match_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/slcp_num.sv =====
module slcp_num
    import slcp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             step,
    input  logic [7:0]       char_in,
    input  logic [NUM_W-1:0] limit,
    output logic             ok,
    output logic [NUM_W-1:0] value
);

    num_state_t       st_reg, st_next;
    logic [4:0]       base_reg, base_next;
    logic             neg_reg, neg_next;
    logic [NUM_W-1:0] val_reg, val_next;
    logic [4:0]       d;
    logic [21:0]      scaled;
    logic [21:0]      acc;

    assign d = digit_of(char_in);

    always_comb
    begin
        unique case (base_reg)
            5'd8:    scaled = {2'b00, val_reg, 3'b000};
            5'd16:   scaled = {1'b0, val_reg, 4'b0000};
            default: scaled = {2'b00, val_reg, 3'b000} + {4'b0000, val_reg, 1'b0};
        endcase
        acc = scaled + 22'(d);
    end

    always_comb
    begin
        st_next   = st_reg;
        base_next = base_reg;
        neg_next  = neg_reg;
        val_next  = val_reg;
        unique case (st_reg)
            NUM_LEAD, NUM_SIGN:
            begin
                if (st_reg == NUM_LEAD && is_blank(char_in))
                begin
                    st_next = NUM_LEAD;
                end
                else if (st_reg == NUM_LEAD &&
                         (char_in == CHAR_PLUS || char_in == CHAR_MINUS))
                begin
                    st_next  = NUM_SIGN;
                    neg_next = (char_in == CHAR_MINUS);
                end
                else if (char_in == CHAR_ZERO)
                begin
                    st_next  = NUM_ZERO;
                    val_next = '0;
                end
                else if (char_in > CHAR_ZERO && char_in <= 8'h39)
                begin
                    st_next   = NUM_DIG;
                    base_next = 5'd10;
                    val_next  = NUM_W'(d);
                end
                else
                begin
                    st_next = NUM_FAIL;
                end
            end
            NUM_ZERO:
            begin
                if ((char_in | 8'h20) == CHAR_X)
                begin
                    st_next = NUM_ZX;
                end
                else if (d < 5'd8)
                begin
                    st_next   = NUM_DIG;
                    base_next = 5'd8;
                    val_next  = NUM_W'(d);
                end
                else
                begin
                    st_next = NUM_FAIL;
                end
            end
            NUM_ZX:
            begin
                if (d < 5'd16)
                begin
                    st_next   = NUM_DIG;
                    base_next = 5'd16;
                    val_next  = NUM_W'(d);
                end
                else
                begin
                    st_next = NUM_FAIL;
                end
            end
            NUM_DIG:
            begin
                if (d < base_reg)
                begin
                    // saturate above 16 bits
                    val_next = (acc > 22'hFFFF) ? NUM_SAT : acc[NUM_W-1:0];
                end
                else
                begin
                    st_next = NUM_FAIL;
                end
            end
            default:
            begin
                st_next = NUM_FAIL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= NUM_LEAD;
            base_reg <= 5'd10;
            neg_reg  <= 1'b0;
        end
        else if (clear)
        begin
            st_reg   <= NUM_LEAD;
            base_reg <= 5'd10;
            neg_reg  <= 1'b0;
        end
        else if (step)
        begin
            st_reg   <= st_next;
            base_reg <= base_next;
            neg_reg  <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            val_reg <= '0;
        end
        else if (step)
        begin
            val_reg <= val_next;
        end
    end

    assign ok    = (st_reg == NUM_ZERO || st_reg == NUM_DIG) &&
                   !(neg_reg && val_reg != '0) && (val_reg <= limit);
    assign value = val_reg;

endmodule

// ===== src/slcp_dp.sv =====
module slcp_dp
    import slcp_pkg::*;
#(
    parameter  int LINE_BYTES = LINE_BYTES_DEF,
    parameter  int CHANNELS   = CHANNELS_DEF,
    parameter  int DUTY_BITS  = DUTY_BITS_DEF,
    localparam int TDATA_W    = ((2 + CHANNELS + DUTY_BITS + BRIGHT_W + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat
);

    localparam int AW       = $clog2(LINE_BYTES);
    localparam int X_W      = DUTY_BITS + BRIGHT_W;
    localparam int P_W      = X_W + 24;
    localparam logic [NUM_W-1:0] MASK_LIMIT = NUM_W'((1 << CHANNELS) - 1);
    localparam logic [X_W-1:0]   DUTY_MAX   = X_W'((1 << DUTY_BITS) - 1);

    logic [7:0]    line_mem [LINE_BYTES];

    logic [AW-1:0] line_len_reg;
    logic          discard_reg;
    logic [AW-1:0] run_len_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          pipe_vld_reg;
    logic [AW-1:0] pipe_idx_reg;
    logic [7:0]    rd_data_reg;
    logic          stop_reg;
    logic          seen_reg;
    logic [AW-1:0] b_reg;
    logic [AW-1:0] e_reg;

    logic f_ping_reg, f_info_reg, f_off_reg, f_rst_reg;
    logic f_brt_reg, f_brsp_reg, f_mask_reg, f_m_reg;

    logic [CHANNELS-1:0] mask_reg;
    logic [BRIGHT_W-1:0] bright_reg;
    logic [1:0]          pend_reply_reg;
    logic [CHANNELS-1:0] pend_mask_reg;
    logic [BRIGHT_W-1:0] pend_bright_reg;
    logic [X_W-1:0]      x_reg;
    logic [P_W-1:0]      prod_reg;

    logic               out_vld_reg;
    logic [TDATA_W-1:0] out_data_reg;

    logic [AW-1:0]  lim;
    logic           issue;
    logic [AW-1:0]  k;
    logic [AW-1:0]  n;
    logic [3:0]     k4;
    logic           mstep;
    logic           ok_a, ok_b, ok_c;
    logic [NUM_W-1:0] val_a, val_b, val_c;
    logic [DUTY_BITS-1:0] duty;

    assign lim   = cmd.scan ? run_len_reg : e_reg;
    assign issue = (cmd.scan && !stop_reg && rd_idx_reg < lim) ||
                   (cmd.match && rd_idx_reg < lim);
    assign k     = pipe_idx_reg - b_reg;
    assign n     = e_reg - b_reg;
    assign k4    = k[3:0];
    assign mstep = cmd.match && pipe_vld_reg;

    // line buffer
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            line_mem[line_len_reg] <= s_tdata;
        end
        rd_data_reg <= line_mem[rd_idx_reg];
    end

    // line collection and both walks over the stored line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg <= '0;
            discard_reg  <= 1'b0;
            run_len_reg  <= '0;
            rd_idx_reg   <= '0;
            pipe_vld_reg <= 1'b0;
            pipe_idx_reg <= '0;
            stop_reg     <= 1'b0;
            seen_reg     <= 1'b0;
            b_reg        <= '0;
            e_reg        <= '0;
        end
        else
        begin
            // no read is issued in the cycle that starts the match walk
            pipe_vld_reg <= issue;
            if (issue)
            begin
                rd_idx_reg   <= rd_idx_reg + 1'b1;
                pipe_idx_reg <= rd_idx_reg;
            end
            if (cmd.store)
            begin
                line_len_reg <= line_len_reg + 1'b1;
            end
            if (cmd.overflow)
            begin
                line_len_reg <= '0;
                discard_reg  <= 1'b1;
            end
            if (cmd.clr_discard)
            begin
                discard_reg <= 1'b0;
            end
            if (cmd.line_end)
            begin
                run_len_reg  <= line_len_reg;
                line_len_reg <= '0;
                rd_idx_reg   <= '0;
                stop_reg     <= 1'b0;
                seen_reg     <= 1'b0;
            end
            // first pass: zero byte cut, first and last non-blank
            if (cmd.scan && pipe_vld_reg && !stop_reg)
            begin
                if (rd_data_reg == 8'd0)
                begin
                    stop_reg <= 1'b1;
                end
                else if (!is_blank(rd_data_reg))
                begin
                    if (!seen_reg)
                    begin
                        b_reg <= pipe_idx_reg;
                    end
                    seen_reg <= 1'b1;
                    e_reg    <= pipe_idx_reg + 1'b1;
                end
            end
            if (cmd.match_start)
            begin
                rd_idx_reg <= b_reg;
            end
        end
    end

    // second pass: keyword match flags
    always_ff @(posedge clk)
    begin
        if (cmd.match_start)
        begin
            f_ping_reg <= 1'b1;
            f_info_reg <= 1'b1;
            f_off_reg  <= 1'b1;
            f_rst_reg  <= 1'b1;
            f_brt_reg  <= 1'b1;
            f_brsp_reg <= 1'b1;
            f_mask_reg <= 1'b1;
            f_m_reg    <= 1'b1;
        end
        else if (mstep)
        begin
            if (k < AW'(4) && rd_data_reg != str_char(STR_PING, 4'd4, k4))
            begin
                f_ping_reg <= 1'b0;
            end
            if (k < AW'(4) && rd_data_reg != str_char(STR_INFO, 4'd4, k4))
            begin
                f_info_reg <= 1'b0;
            end
            if (k < AW'(3) && rd_data_reg != str_char(STR_OFF, 4'd3, k4))
            begin
                f_off_reg <= 1'b0;
            end
            if (k < AW'(5) && rd_data_reg != str_char(STR_RESET, 4'd5, k4))
            begin
                f_rst_reg <= 1'b0;
            end
            if (k < AW'(10) && rd_data_reg != str_char(STR_BRIGHT, 4'd10, k4))
            begin
                f_brt_reg <= 1'b0;
            end
            if (k == AW'(10) && rd_data_reg != CHAR_SPACE)
            begin
                f_brsp_reg <= 1'b0;
            end
            if (k < AW'(5) && rd_data_reg != str_char(STR_MASK, 4'd5, k4))
            begin
                f_mask_reg <= 1'b0;
            end
            if (k < AW'(1) && rd_data_reg != str_char(STR_M, 4'd1, k4))
            begin
                f_m_reg <= 1'b0;
            end
        end
    end

    // number readers after "MASK ", after "M" and after "BRIGHTNESS "
    slcp_num u_num_mask (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cmd.match_start),
        .step    (mstep && k >= AW'(5)),
        .char_in (rd_data_reg),
        .limit   (MASK_LIMIT),
        .ok      (ok_a),
        .value   (val_a)
    );

    slcp_num u_num_m (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cmd.match_start),
        .step    (mstep && k >= AW'(1)),
        .char_in (rd_data_reg),
        .limit   (MASK_LIMIT),
        .ok      (ok_b),
        .value   (val_b)
    );

    slcp_num u_num_bright (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cmd.match_start),
        .step    (mstep && k >= AW'(11)),
        .char_in (rd_data_reg),
        .limit   (NUM_W'(BRIGHT_MAX)),
        .ok      (ok_c),
        .value   (val_c)
    );

    // command decision and overflow error, state update held back until the result is loaded for output
    always_ff @(posedge clk)
    begin
        if (cmd.overflow)
        begin
            pend_reply_reg  <= REPLY_ERR;
            pend_mask_reg   <= mask_reg;
            pend_bright_reg <= bright_reg;
        end
        else if (cmd.decide)
        begin
            pend_mask_reg   <= mask_reg;
            pend_bright_reg <= bright_reg;
            priority if ((f_ping_reg || f_info_reg) && n == AW'(4))
            begin
                pend_reply_reg <= REPLY_INFO;
            end
            else if ((f_off_reg && n == AW'(3)) || (f_rst_reg && n == AW'(5)))
            begin
                pend_reply_reg <= REPLY_NONE;
                pend_mask_reg  <= '0;
            end
            else if (f_brt_reg && n == AW'(10))
            begin
                pend_reply_reg <= REPLY_INFO;
            end
            else if (f_mask_reg && n >= AW'(5) && ok_a)
            begin
                pend_reply_reg <= REPLY_NONE;
                pend_mask_reg  <= val_a[CHANNELS-1:0];
            end
            else if (f_m_reg && n >= AW'(2) && ok_b)
            begin
                pend_reply_reg <= REPLY_NONE;
                pend_mask_reg  <= val_b[CHANNELS-1:0];
            end
            else if (f_brt_reg && f_brsp_reg && n >= AW'(11) && ok_c)
            begin
                pend_reply_reg  <= REPLY_INFO;
                pend_bright_reg <= val_c[BRIGHT_W-1:0];
            end
            else
            begin
                pend_reply_reg <= REPLY_ERR;
            end
        end
    end

    // duty = full_scale * percent / 100 by reciprocal, two registered multiplies
    always_ff @(posedge clk)
    begin
        x_reg    <= DUTY_MAX * X_W'(pend_bright_reg);
        prod_reg <= P_W'(x_reg) * P_W'(RECIP_100);
    end

    assign duty = prod_reg[RECIP_SHIFT +: DUTY_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '0;
            bright_reg  <= BRIGHT_RESET;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                mask_reg    <= pend_mask_reg;
                bright_reg  <= pend_bright_reg;
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= TDATA_W'({pend_bright_reg, duty, pend_mask_reg, pend_reply_reg});
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    assign stat.eol        = (s_tdata == CHAR_LF) || (s_tdata == CHAR_CR);
    assign stat.discarding = discard_reg;
    assign stat.len_zero   = (line_len_reg == '0);
    assign stat.len_full   = (line_len_reg == AW'(LINE_BYTES - 1));
    assign stat.scan_done  = !pipe_vld_reg && (rd_idx_reg >= run_len_reg || stop_reg);
    assign stat.nonempty   = seen_reg;
    assign stat.match_done = !pipe_vld_reg && (rd_idx_reg >= e_reg);
    assign stat.out_free   = !out_vld_reg || m_tready;

endmodule

// ===== src/slcp_checker.sv =====
module slcp_checker
    import slcp_pkg::*;
#(
    parameter  int CHANNELS  = CHANNELS_DEF,
    parameter  int DUTY_BITS = DUTY_BITS_DEF,
    localparam int TDATA_W   = ((2 + CHANNELS + DUTY_BITS + BRIGHT_W + 7) / 8) * 8,
    localparam int B_LO      = 2 + CHANNELS + DUTY_BITS
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reply: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == REPLY_NONE || m_tdata[1:0] == REPLY_INFO ||
                      m_tdata[1:0] == REPLY_ERR))
        else $error("bad reply code");

    a_bright: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[B_LO +: BRIGHT_W] <= BRIGHT_MAX)
        else $error("brightness above limit");

    // a new result is only handed off while the input is held off
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without cause");

endmodule

bind serial_line_light_command_parser_core slcp_checker #(
    .CHANNELS  (CHANNELS),
    .DUTY_BITS (DUTY_BITS)
) u_slcp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/tb_serial_line_light_command_parser_core.sv =====
`timescale 1ns / 1ps

module tb_serial_line_light_command_parser_core;
    import slcp_pkg::*;

    // result fields as they sit in m_tdata, highest bits first
    typedef struct packed {
        logic [6:0] brightness;
        logic [7:0] on_duty;
        logic [3:0] channel_mask;
        logic [1:0] reply;
    } light_status_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    // predictor state
    logic [7:0] line_buf [0:63];
    int         line_len;
    bit         dropping;
    logic [3:0] mask_now;
    int         bright_now;

    light_status_t status_q[$];
    int  error_count;
    int  bytes_sent;
    int  lines_sent;
    int  status_seen;
    int  overflow_count;
    bit  idle_on;
    int  hold_cycles;
    int  ready_wait;

    serial_line_light_command_parser_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    function automatic bit blank_char(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 99;
    endfunction

    function automatic bit text_is(input int b, input int n, input string s);
        if (n != s.len()) return 0;
        for (int k = 0; k < n; k++)
        begin
            if (line_buf[b + k] != s[k]) return 0;
        end
        return 1;
    endfunction

    function automatic bit text_starts(input int b, input int n, input string s);
        if (n < s.len()) return 0;
        for (int k = 0; k < s.len(); k++)
        begin
            if (line_buf[b + k] != s[k]) return 0;
        end
        return 1;
    endfunction

    // strtol base 0 style, whole text consumed, saturating at 0x10000
    function automatic bit parse_number(input int s, input int n, input int lim,
                                        output int v);
        int i;
        int base;
        int val;
        int d;
        bit neg;
        i = 0;
        base = 10;
        val = 0;
        neg = 0;
        v = 0;
        while (i < n && blank_char(line_buf[s + i])) i++;
        if (i < n && (line_buf[s + i] == "+" || line_buf[s + i] == "-"))
        begin
            neg = line_buf[s + i] == "-";
            i++;
        end
        if (i < n && line_buf[s + i] == "0")
        begin
            if (i + 2 < n && (line_buf[s + i + 1] | 8'h20) == "x"
                && hex_value(line_buf[s + i + 2]) < 16)
            begin
                base = 16;
                i += 2;
            end
            else
            begin
                base = 8;
            end
        end
        if (i >= n) return 0;
        for (; i < n; i++)
        begin
            d = hex_value(line_buf[s + i]);
            if (d >= base) return 0;
            val = val * base + d;
            if (val > 65535) val = 65536;
        end
        if (neg && val != 0) return 0;
        if (val > lim) return 0;
        v = val;
        return 1;
    endfunction

    function automatic light_status_t status_now(input logic [1:0] r);
        light_status_t t;
        t.reply        = r;
        t.channel_mask = mask_now;
        t.on_duty      = 8'((255 * bright_now) / 100);
        t.brightness   = 7'(bright_now);
        return t;
    endfunction

    // work out the result of a closed line, if any
    task automatic finish_line(input int len);
        int eff;
        int b;
        int e;
        int n;
        int v;
        logic [1:0] r;
        eff = 0;
        while (eff < len && line_buf[eff] != 8'd0) eff++;
        b = 0;
        while (b < eff && blank_char(line_buf[b])) b++;
        e = eff;
        while (e > b && blank_char(line_buf[e - 1])) e--;
        n = e - b;
        if (n == 0) return;
        if (text_is(b, n, "PING") || text_is(b, n, "INFO") || text_is(b, n, "BRIGHTNESS"))
        begin
            r = REPLY_INFO;
        end
        else if (text_is(b, n, "OFF") || text_is(b, n, "RESET"))
        begin
            mask_now = 4'd0;
            r = REPLY_NONE;
        end
        else if (text_starts(b, n, "MASK ") && parse_number(b + 5, n - 5, 15, v))
        begin
            mask_now = 4'(v);
            r = REPLY_NONE;
        end
        else if (line_buf[b] == "M" && n >= 2 && parse_number(b + 1, n - 1, 15, v))
        begin
            mask_now = 4'(v);
            r = REPLY_NONE;
        end
        else if (text_starts(b, n, "BRIGHTNESS ") && parse_number(b + 11, n - 11, 100, v))
        begin
            bright_now = v;
            r = REPLY_INFO;
        end
        else
        begin
            r = REPLY_ERR;
        end
        status_q.push_back(status_now(r));
    endtask

    task automatic predict_byte(input logic [7:0] c);
        int len;
        if (c == CHAR_LF || c == CHAR_CR)
        begin
            len = line_len;
            line_len = 0;
            if (dropping)
            begin
                dropping = 0;
            end
            else if (len != 0)
            begin
                finish_line(len);
            end
        end
        else if (!dropping)
        begin
            if (line_len + 1 >= 64)
            begin
                line_len = 0;
                dropping = 1;
                overflow_count++;
                status_q.push_back(status_now(REPLY_ERR));
            end
            else
            begin
                line_buf[line_len] = c;
                line_len++;
            end
        end
    endtask

    // offer one byte, after a random gap while idle_on is set, and wait for the handshake
    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
        predict_byte(c);
        bytes_sent++;
    endtask

    task automatic send_line(input string s, input logic [7:0] term = CHAR_LF);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
        send_byte(term);
        lines_sent++;
    endtask

    task automatic drain_status();
        wait (status_q.size() == 0);
        repeat (150) @(posedge clk);
    endtask

    // receiver: a random stall after each item while idle_on is set, plus the long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else if (ready_wait > 0)
        begin
            ready_wait <= ready_wait - 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        light_status_t got;
        light_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = light_status_t'(m_tdata[20:0]);
            status_seen++;
            ready_wait <= idle_on ? $urandom_range(0, 11) : 0;
            if (status_q.size() == 0)
            begin
                $error("unexpected item: %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = status_q.pop_front();
                if (got.reply !== want.reply)
                begin
                    $error("reply: expected %0d, got %0d", want.reply, got.reply);
                    error_count++;
                end
                if (got.channel_mask !== want.channel_mask)
                begin
                    $error("channel_mask: expected %h, got %h",
                           want.channel_mask, got.channel_mask);
                    error_count++;
                end
                if (got.on_duty !== want.on_duty)
                begin
                    $error("on_duty: expected %0d, got %0d", want.on_duty, got.on_duty);
                    error_count++;
                end
                if (got.brightness !== want.brightness)
                begin
                    $error("brightness: expected %0d, got %0d",
                           want.brightness, got.brightness);
                    error_count++;
                end
                if (m_tdata[23:21] !== 3'd0)
                begin
                    $error("zero fill: expected 0, got %h", m_tdata[23:21]);
                    error_count++;
                end
            end
        end
    end

    // random number text in one of the strtol forms
    function automatic string number_text(input int lim);
        int v;
        string sgn;
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200000) : $urandom_range(0, lim + 3);
        case ($urandom_range(0, 5))
            0: sgn = "+";
            1: sgn = "-";
            default: sgn = "";
        endcase
        case ($urandom_range(0, 3))
            0: return {sgn, $sformatf("0x%0h", v)};
            1: return {sgn, $sformatf("0X%0H", v)};
            2: return {sgn, $sformatf("0%0o", v)};
            default: return {sgn, $sformatf("%0d", v)};
        endcase
    endfunction

    function automatic string pad_text();
        string s;
        s = "";
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 2))
                0: s = {s, " "};
                1: s = {s, "\t"};
                default: s = {s, string'(8'd11)};
            endcase
        end
        return s;
    endfunction

    function automatic string noise_text(input int n);
        string s;
        logic [7:0] c;
        s = "";
        for (int k = 0; k < n; k++)
        begin
            c = 8'($urandom_range(0, 255));
            if (c == CHAR_LF || c == CHAR_CR || c == 8'd0) c = "#";
            s = {s, string'(c)};
        end
        return s;
    endfunction

    // zero bytes do not survive in a string, so these lines go byte by byte
    task automatic send_cut_line(input string head, input string tail);
        for (int k = 0; k < head.len(); k++) send_byte(head[k]);
        send_byte(8'd0);
        for (int k = 0; k < tail.len(); k++) send_byte(tail[k]);
        send_byte(CHAR_CR);
        lines_sent++;
    endtask

    task automatic send_overlong();
        int n;
        n = $urandom_range(64, 90);
        repeat (n) send_byte(8'($urandom_range(33, 126)));
        send_byte(($urandom_range(0, 1) != 0) ? CHAR_LF : CHAR_CR);
        lines_sent++;
    endtask

    task automatic test_commands();
        send_line("PING");
        send_line("INFO", CHAR_CR);
        send_line("BRIGHTNESS");
        send_line("MASK 15");
        send_line("OFF");
        send_line("M0xF");
        send_line("RESET");
        send_line(" \t M017 \t ");
        send_line("BRIGHTNESS 0");
        send_line("BRIGHTNESS 100");
        send_line("BRIGHTNESS 101");
        send_line("BRIGHTNESS 0x3f");
        send_line("M-0");
        send_line("M+3");
        send_line("M 5");
        send_line("M-1");
        send_line("MASK 16");
        send_line("MASK 99999999");
        send_line("M");
        send_line("M0x");
        send_line("ping");
        send_line("");
        send_line("   \t ");
        send_cut_line("PING", "XYZ");
        drain_status();
    endtask

    task automatic test_overflow();
        send_overlong();
        send_line(noise_text(62));
        send_overlong();
        send_line("PING");
        drain_status();
    endtask

    // output held off while the sender keeps offering short lines
    task automatic test_backpressure();
        hold_cycles = 400;
        repeat (6) send_line("INFO");
        drain_status();
    endtask

    task automatic test_random();
        int kind;
        int start;
        start = bytes_sent;
        while (bytes_sent - start < 150)
        begin
            if ($urandom_range(0, 49) == 0) idle_on = !idle_on;
            kind = $urandom_range(0, 19);
            case (kind)
                0, 1: send_line({pad_text(), "MASK ", pad_text(), number_text(15), pad_text()});
                2, 3: send_line({pad_text(), "M", number_text(15), pad_text()});
                4, 5: send_line({"BRIGHTNESS ", pad_text(), number_text(100), pad_text()});
                6:    send_line({pad_text(), "PING", pad_text()});
                7:    send_line("INFO", CHAR_CR);
                8:    send_line({pad_text(), "BRIGHTNESS"});
                9:    send_line("OFF");
                10:   send_line("RESET");
                11:   send_line(noise_text($urandom_range(0, 12)));
                12:   send_line(pad_text());
                13:   send_cut_line("M", noise_text($urandom_range(0, 4)));
                14:   send_overlong();
                15:   send_line("MASK");
                16:   send_line({"BRIGHTNESS", number_text(100)});
                17:
                begin
                    // line ended CR then LF: the second ending closes an empty line
                    send_line({"M", number_text(15)}, CHAR_CR);
                    send_byte(CHAR_LF);
                end
                18:   send_line({"MASK ", number_text(15), "z"});
                default:
                begin
                    // random byte values on the input, line ends included
                    repeat (8) send_byte(8'($urandom_range(0, 255)));
                    send_byte(CHAR_LF);
                end
            endcase
            if ($urandom_range(0, 99) == 0) wait (status_q.size() == 0);
            if ($urandom_range(0, 199) == 0) hold_cycles = 200;
        end
        idle_on = 1;
    endtask

    initial
    begin
        #2_000_000;
        $display("tb_serial_line_light_command_parser_core: done, errors");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        m_tready = 1'b0;
        line_len = 0;
        dropping = 0;
        mask_now = 4'd0;
        bright_now = 75;
        error_count = 0;
        bytes_sent = 0;
        lines_sent = 0;
        status_seen = 0;
        overflow_count = 0;
        idle_on = 1;
        hold_cycles = 0;
        ready_wait = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_commands();
        test_overflow();
        test_backpressure();
        test_random();

        @(negedge clk);
        s_tvalid <= 1'b0;
        drain_status();

        $display("%0d bytes in %0d lines, %0d result items checked, %0d overlong lines",
                 bytes_sent, lines_sent, status_seen, overflow_count);
        if (error_count == 0)
        begin
            $display("tb_serial_line_light_command_parser_core: done, clean");
        end
        else
        begin
            $display("tb_serial_line_light_command_parser_core: done, errors");
        end
        $finish;
    end

endmodule
